// ----- rtl/gtr_pkg.sv -----
// ============================================================================
// gtr_pkg
// Shared constants for the glyph text rasterizer: screen geometry, glyph
// store sizing, item kinds and field widths.
// ============================================================================
package gtr_pkg;

    // Screen geometry of the rotated, column-major framebuffer.
    localparam int SCREEN_ROWS    = 240;
    localparam int SCREEN_COLUMNS = 400;
    localparam int GLYPH_COUNT    = 256;

    // Glyph cell and pixel format.
    localparam int GLYPH_SIDE      = 8;
    localparam int BYTES_PER_PIXEL = 3;
    localparam int STORE_DEPTH     = GLYPH_COUNT * GLYPH_SIDE;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int CODE_W   = 8;
    localparam int ROW_W    = 3;
    localparam int BITS_W   = 8;
    localparam int SX_W     = 9;
    localparam int SY_W     = 8;
    localparam int COLOR_W  = 24;
    localparam int OFF_W    = 19;
    localparam int PITCH_W  = 6;
    localparam int CURY_W   = 10;
    localparam int COLCNT_W = 6;
    localparam int POS_W    = 11;

    // Input and output bus widths, padded to whole bytes.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    // Item kinds carried on the input tuser.
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd2;

    // Special character codes and limits.
    localparam logic [CODE_W-1:0]   NEWLINE_CODE  = 8'd10;
    localparam logic [COLCNT_W-1:0] COLCNT_MAX    = 6'd63;
    localparam logic [CURY_W-1:0]   CURSOR_Y_MAX  = 10'd1023;
    localparam logic [PITCH_W-1:0]  PITCH_RESET   = 6'd10;

endpackage

// ----- rtl/gtr_ram.sv -----
// ============================================================================
// gtr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ============================================================================
module gtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/glyph_text_rasterizer.sv -----
// ============================================================================
// glyph_text_rasterizer
// Renders 8x8 bitmap-font text into a rotated, column-major framebuffer,
// emitting one write item per lit on-screen glyph pixel.
// ============================================================================
//
// Channel   Direction  Signals                         Contents
// s_axis    in         tvalid/tready/tdata/tuser       load, start or character
// m_axis    out        tvalid/tready/tdata/tlast       pixel write
// cfg       in         i_cfg_we/i_cfg_wdata            line pitch register
//
// A load, start, newline or ignored item is handled in the idle state. A
// character passes through setup for the column-base multiply, a scan of
// the 64 glyph bits one per cycle through the shared offset adder, and a
// flush of the held last pixel. Output back-pressure stalls scan and flush.
// Reset is synchronous and active low; the glyph store is not cleared.
// The input is ready only while the sequencer is idle.
//
module glyph_text_rasterizer
    import gtr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Line pitch register.
    input  logic                  i_cfg_we,
    input  logic [PITCH_W-1:0]    i_cfg_wdata,
    // Input items.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] char_code, [10:8] row_index, [18:11] row_bits, [27:19] start_x,
    // [35:28] start_y, [59:36] rgb_color, [63:60] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]     i_s_axis_tuser,
    // Pixel write items.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [18:0] byte_offset, [26:19] red, [34:27] green, [42:35] blue,
    // [47:43] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // last_pixel
    output logic                  o_m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    localparam logic [OFF_W-1:0] COL_STEP  = OFF_W'(SCREEN_ROWS * BYTES_PER_PIXEL);
    localparam logic [OFF_W-1:0] ROW_STEP  = OFF_W'(BYTES_PER_PIXEL);
    localparam logic [OFF_W-1:0] ROW_LAST  = OFF_W'(SCREEN_ROWS - 1);
    localparam logic [POS_W-1:0] COL_LIMIT = POS_W'(SCREEN_COLUMNS);
    localparam logic [POS_W-1:0] ROW_LIMIT = POS_W'(SCREEN_ROWS);
    localparam logic [ROW_W-1:0] SIDE_LAST = ROW_W'(GLYPH_SIDE - 1);

    t_state               r_state;
    logic [PITCH_W-1:0]   r_pitch;
    logic [SX_W-1:0]      r_origin_x;
    logic [CURY_W-1:0]    r_cursor_y;
    logic [COLCNT_W-1:0]  r_column_count;
    logic [COLOR_W-1:0]   r_color;
    logic [CODE_W-1:0]    r_code;
    logic                 r_glyph_ok;
    logic [POS_W-1:0]     r_base_x;
    logic [POS_W-1:0]     r_px;
    logic [POS_W-1:0]     r_py;
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     r_col;
    logic [OFF_W-1:0]     r_col_base;
    logic [OFF_W-1:0]     r_col_off;
    logic [OFF_W-1:0]     r_row_off;
    logic                 r_pend_valid;
    logic [OFF_W-1:0]     r_pend_off;
    logic                 r_out_valid;
    logic [OFF_W-1:0]     r_out_off;
    logic [COLOR_W-1:0]   r_out_color;
    logic                 r_out_last;

    // Input field unpacking.
    logic [KIND_W-1:0]  in_kind;
    logic [CODE_W-1:0]  in_code;
    logic [ROW_W-1:0]   in_row;
    logic [BITS_W-1:0]  in_bits;
    logic [SX_W-1:0]    in_sx;
    logic [SY_W-1:0]    in_sy;
    logic [COLOR_W-1:0] in_color;

    assign in_kind  = i_s_axis_tuser;
    assign in_code  = i_s_axis_tdata[7:0];
    assign in_row   = i_s_axis_tdata[10:8];
    assign in_bits  = i_s_axis_tdata[18:11];
    assign in_sx    = i_s_axis_tdata[27:19];
    assign in_sy    = i_s_axis_tdata[35:28];
    assign in_color = i_s_axis_tdata[59:36];

    logic accept;
    logic code_ok;
    logic out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign code_ok         = ({1'b0, in_code} < 9'(GLYPH_COUNT));
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Glyph store access.
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic                ram_re;
    logic [STORE_AW-1:0] ram_raddr;
    logic [BITS_W-1:0]   ram_rdata;
    logic [CODE_W+ROW_W-1:0] waddr_full;
    logic [CODE_W+ROW_W-1:0] raddr_full;

    assign waddr_full = {in_code, in_row};
    assign ram_we     = accept && (in_kind == KIND_LOAD) && code_ok;
    assign ram_waddr  = waddr_full[STORE_AW-1:0];

    gtr_ram #(
        .WIDTH(BITS_W),
        .DEPTH(STORE_DEPTH)
    ) u_font_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(in_bits),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Pixel test for the current scan position.
    logic pix_bit;
    logic pix_hit;
    logic scan_stall;
    logic row_end;

    assign pix_bit    = ram_rdata[SIDE_LAST - r_col];
    assign pix_hit    = pix_bit && (r_px < COL_LIMIT) && (r_py < ROW_LIMIT);
    assign scan_stall = pix_hit && r_pend_valid && !out_free;
    assign row_end    = (r_col == SIDE_LAST);

    // Read the next glyph row: row zero in setup, the following row at the
    // end of each scanned row.
    always_comb begin
        ram_re     = 1'b0;
        raddr_full = {r_code, {ROW_W{1'b0}}};
        case (r_state)
            ST_SETUP: begin
                ram_re = r_glyph_ok;
            end
            ST_SCAN: begin
                ram_re     = !scan_stall && row_end && (r_row != SIDE_LAST);
                raddr_full = {r_code, r_row + ROW_W'(1)};
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end
    assign ram_raddr = raddr_full[STORE_AW-1:0];

    // Output register load: a held pixel moves out when a newer one is found,
    // or at the flush with the last mark.
    logic load_out;
    logic load_last;

    always_comb begin
        load_out  = 1'b0;
        load_last = 1'b0;
        case (r_state)
            ST_SCAN: begin
                load_out = pix_hit && r_pend_valid && out_free;
            end
            ST_FLUSH: begin
                load_out  = r_pend_valid && out_free;
                load_last = 1'b1;
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // Next cursor row after a newline, saturating.
    logic [CURY_W:0] newline_y;
    assign newline_y = {1'b0, r_cursor_y} + (CURY_W + 1)'(r_pitch);

    // Origin row offset of the glyph cell, modulo the offset width.
    logic [OFF_W-1:0] row_delta;
    assign row_delta = ROW_LAST - OFF_W'(r_cursor_y);

    // Sequencer and registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_pitch        <= PITCH_RESET;
            r_origin_x     <= '0;
            r_cursor_y     <= '0;
            r_column_count <= '0;
            r_color        <= '0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pitch <= i_cfg_wdata;
            end

            // Output register.
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_off   <= r_pend_off;
                r_out_color <= r_color;
                r_out_last  <= load_last;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (in_kind)
                            KIND_START: begin
                                r_origin_x     <= in_sx;
                                r_cursor_y     <= CURY_W'(in_sy);
                                r_column_count <= '0;
                                r_color        <= in_color;
                            end
                            KIND_CHAR: begin
                                if (in_code == NEWLINE_CODE) begin
                                    r_cursor_y     <= newline_y[CURY_W] ? CURSOR_Y_MAX
                                                                        : newline_y[CURY_W-1:0];
                                    r_column_count <= '0;
                                end else begin
                                    r_code     <= in_code;
                                    r_glyph_ok <= code_ok;
                                    r_base_x   <= POS_W'(r_origin_x)
                                                + POS_W'({r_column_count, 3'b000});
                                    r_state    <= ST_SETUP;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_SETUP: begin
                    // One multiply gives the column base; rows step by adds.
                    r_col_base <= OFF_W'(r_base_x * COL_STEP);
                    r_col_off  <= OFF_W'(r_base_x * COL_STEP);
                    r_row_off  <= (row_delta << 1) + row_delta;
                    r_px       <= r_base_x;
                    r_py       <= POS_W'(r_cursor_y);
                    r_row      <= '0;
                    r_col      <= '0;
                    r_state    <= r_glyph_ok ? ST_SCAN : ST_FLUSH;
                end

                ST_SCAN: begin
                    if (!scan_stall) begin
                        if (pix_hit) begin
                            r_pend_valid <= 1'b1;
                            r_pend_off   <= r_col_off + r_row_off;
                        end
                        if (row_end) begin
                            r_col     <= '0;
                            r_px      <= r_base_x;
                            r_col_off <= r_col_base;
                            r_row_off <= r_row_off - ROW_STEP;
                            r_py      <= r_py + POS_W'(1);
                            r_row     <= r_row + ROW_W'(1);
                            if (r_row == SIDE_LAST) begin
                                r_state <= ST_FLUSH;
                            end
                        end else begin
                            r_col     <= r_col + ROW_W'(1);
                            r_px      <= r_px + POS_W'(1);
                            r_col_off <= r_col_off + COL_STEP;
                        end
                    end
                end

                ST_FLUSH: begin
                    if (!r_pend_valid || out_free) begin
                        r_pend_valid <= 1'b0;
                        if (r_column_count != COLCNT_MAX) begin
                            r_column_count <= r_column_count + COLCNT_W'(1);
                        end
                        r_state <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output packing.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {5'b00000, r_out_color[7:0], r_out_color[15:8],
                              r_out_color[23:16], r_out_off};

endmodule

// ----- verif/tb.sv -----
// ============================================================================
// tb
// Self-checking testbench for the glyph text rasterizer. It loads glyphs,
// starts strings and draws characters and newlines, predicts every pixel
// write from its own model of the font store and the text cursor, and checks
// each write field by field. Both stream sides idle at random, and the line
// pitch register is changed between phases while the block is quiet.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gtr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_PERCENT  = 32;
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int REPORT_LIMIT  = 10;

    // One framebuffer pixel write, fields in bus order from the lowest bit up.
    typedef struct packed {
        logic [OFF_W-1:0] byte_offset;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             last_pixel;
    } pixel_write_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [PITCH_W-1:0]    i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [KIND_W-1:0]     i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;

    // Predicted state of the block.
    logic [BITS_W-1:0]   font_rows [STORE_DEPTH];
    logic [7:0]          glyph_rows_loaded [GLYPH_COUNT];
    logic [SX_W-1:0]     text_origin_x;
    logic [CURY_W-1:0]   text_row;
    logic [COLCNT_W-1:0] cell_column;
    logic [COLOR_W-1:0]  ink_color;
    logic [PITCH_W-1:0]  pitch_rows;

    pixel_write_t expected_pixels [$];
    int           drawable_codes [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           no_idle = 1'b0;

    glyph_text_rasterizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Pack the input fields into tdata, lowest field first.
    function automatic logic [IN_DATA_W-1:0] pack_item(
        input logic [CODE_W-1:0]  code,
        input logic [ROW_W-1:0]   row,
        input logic [BITS_W-1:0]  bits,
        input logic [SX_W-1:0]    sx,
        input logic [SY_W-1:0]    sy,
        input logic [COLOR_W-1:0] color
    );
        pack_item = '0;
        pack_item[59:0] = {color, sy, sx, bits, row, code};
    endfunction

    // Predict the pixel writes that one accepted item causes.
    function automatic void rasterize_item(input logic [KIND_W-1:0] kind,
                                           input logic [IN_DATA_W-1:0] data);
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [BITS_W-1:0] pattern;
        int                base_x;
        int                px;
        int                py;
        int                off;
        int                next_row;
        pixel_write_t      pend;
        bit                have_pend;
        code = data[7:0];
        row = data[10:8];
        have_pend = 1'b0;
        pend = '0;
        case (kind)
            KIND_LOAD: begin
                font_rows[code * GLYPH_SIDE + row] = data[18:11];
                if (glyph_rows_loaded[code] != 8'hFF) begin
                    glyph_rows_loaded[code][row] = 1'b1;
                    if (glyph_rows_loaded[code] == 8'hFF)
                        drawable_codes.push_back(int'(code));
                end
            end
            KIND_START: begin
                text_origin_x = data[27:19];
                text_row = CURY_W'(data[35:28]);
                cell_column = '0;
                ink_color = data[59:36];
            end
            KIND_CHAR: begin
                if (code == NEWLINE_CODE) begin
                    next_row = int'(text_row) + int'(pitch_rows);
                    text_row = (next_row > int'(CURSOR_Y_MAX)) ? CURSOR_Y_MAX
                                                               : CURY_W'(next_row);
                    cell_column = '0;
                end else begin
                    base_x = int'(text_origin_x) + int'(cell_column) * GLYPH_SIDE;
                    // Scan rows top down and each row from its leftmost bit.
                    for (int r = 0; r < GLYPH_SIDE; r++) begin
                        pattern = font_rows[code * GLYPH_SIDE + r];
                        py = int'(text_row) + r;
                        for (int c = 0; c < GLYPH_SIDE; c++) begin
                            px = base_x + c;
                            if (pattern[GLYPH_SIDE - 1 - c] && px < SCREEN_COLUMNS &&
                                py < SCREEN_ROWS) begin
                                if (have_pend)
                                    expected_pixels.push_back(pend);
                                off = (px * SCREEN_ROWS + (SCREEN_ROWS - 1 - py)) *
                                      BYTES_PER_PIXEL;
                                pend.byte_offset = OFF_W'(off);
                                pend.red = ink_color[23:16];
                                pend.green = ink_color[15:8];
                                pend.blue = ink_color[7:0];
                                pend.last_pixel = 1'b0;
                                have_pend = 1'b1;
                            end
                        end
                    end
                    if (have_pend) begin
                        pend.last_pixel = 1'b1;
                        expected_pixels.push_back(pend);
                    end
                    if (cell_column < COLCNT_MAX)
                        cell_column = cell_column + 1'b1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Check each accepted pixel write and drive the output ready.
    always @(posedge i_clk) begin
        pixel_write_t want;
        pixel_write_t got;
        got = {o_m_axis_tdata[18:0], o_m_axis_tdata[26:19], o_m_axis_tdata[34:27],
               o_m_axis_tdata[42:35], o_m_axis_tlast};
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected write: off=%0d rgb=%02h%02h%02h last=%0b",
                             got.byte_offset, got.red, got.green, got.blue,
                             got.last_pixel);
            end else begin
                want = expected_pixels.pop_front();
                if (got != want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("write mismatch: expected off=%0d rgb=%02h%02h%02h last=%0b",
                                 want.byte_offset, want.red, want.green, want.blue,
                                 want.last_pixel);
                        $display("                got off=%0d rgb=%02h%02h%02h last=%0b",
                                 got.byte_offset, got.red, got.green, got.blue,
                                 got.last_pixel);
                    end
                end
            end
        end
        i_m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Send one item, with random idle cycles ahead of it.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [IN_DATA_W-1:0] data);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= data;
        i_s_axis_tuser <= kind;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        rasterize_item(kind, data);
    endtask

    task automatic send_load(input logic [CODE_W-1:0] code, input logic [ROW_W-1:0] row,
                             input logic [BITS_W-1:0] bits);
        send_item(KIND_LOAD, pack_item(code, row, bits, SX_W'($urandom),
                                       SY_W'($urandom), COLOR_W'($urandom)));
    endtask

    task automatic send_start(input logic [SX_W-1:0] sx, input logic [SY_W-1:0] sy,
                              input logic [COLOR_W-1:0] color);
        send_item(KIND_START, pack_item(CODE_W'($urandom), ROW_W'($urandom),
                                        BITS_W'($urandom), sx, sy, color));
    endtask

    task automatic send_char(input logic [CODE_W-1:0] code);
        send_item(KIND_CHAR, pack_item(code, ROW_W'($urandom), BITS_W'($urandom),
                                       SX_W'($urandom), SY_W'($urandom),
                                       COLOR_W'($urandom)));
    endtask

    // Mostly on-screen origins, sometimes anywhere the field reaches.
    function automatic logic [SX_W-1:0] random_origin_x();
        if ($urandom_range(0, 99) < 90)
            return SX_W'($urandom_range(0, SCREEN_COLUMNS - 1));
        return SX_W'($urandom);
    endfunction

    function automatic logic [SY_W-1:0] random_origin_y();
        if ($urandom_range(0, 99) < 90)
            return SY_W'($urandom_range(0, SCREEN_ROWS - 1));
        return SY_W'($urandom);
    endfunction

    // A newline now and then, otherwise a glyph whose rows are all loaded.
    function automatic logic [CODE_W-1:0] random_text_code();
        if ($urandom_range(0, 99) < 15)
            return NEWLINE_CODE;
        return CODE_W'(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
    endfunction

    // Stop sending and wait until every expected write has come out, then let
    // a possible empty character finish its scan.
    task automatic wait_until_quiet();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_pitch(input logic [PITCH_W-1:0] value);
        wait_until_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        pitch_rows = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reset_dut();
        text_origin_x = '0;
        text_row = '0;
        cell_column = '0;
        ink_color = '0;
        pitch_rows = PITCH_RESET;
        for (int g = 0; g < GLYPH_COUNT; g++)
            glyph_rows_loaded[g] = '0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    // Full and patterned glyphs at the screen corners, clipping, an empty
    // character and an ignored kind.
    task automatic test_directed_glyphs();
        logic [7:0] patterns [8] = '{8'h80, 8'h01, 8'hAA, 8'h55,
                                     8'h00, 8'hFF, 8'h81, 8'h7E};
        for (int r = 0; r < GLYPH_SIDE; r++)
            send_load(8'd0, ROW_W'(r), 8'hFF);
        for (int r = 0; r < GLYPH_SIDE; r++)
            send_load(8'd255, ROW_W'(r), patterns[r]);
        send_start(9'd0, 8'd0, 24'hFFFFFF);
        send_char(8'd0);
        send_char(8'd255);
        send_char(NEWLINE_CODE);
        send_char(8'd255);
        // Rightmost column: only the first glyph column is on the screen.
        send_start(9'd399, 8'd0, 24'h000000);
        send_char(8'd0);
        send_char(8'd0);
        // Bottom rows beyond the screen: the character draws nothing.
        send_start(9'd0, 8'd255, 24'hA5C3E1);
        send_char(8'd0);
        send_start(9'd392, 8'd239, 24'h5A3C1E);
        send_char(8'd255);
        send_item(KIND_UNUSED, pack_item(CODE_W'($urandom), ROW_W'($urandom),
                                         BITS_W'($urandom), SX_W'($urandom),
                                         SY_W'($urandom), COLOR_W'($urandom)));
    endtask

    // Newlines at the pitch extremes, including a pitch of zero.
    task automatic test_line_pitch_extremes();
        logic [PITCH_W-1:0] pitches [5] = '{6'd0, 6'd63, 6'd8, 6'd32, 6'd17};
        for (int p = 0; p < 5; p++) begin
            write_line_pitch(pitches[p]);
            send_start(random_origin_x(), SY_W'($urandom_range(0, 120)),
                       COLOR_W'($urandom));
            send_char(8'd255);
            send_char(NEWLINE_CODE);
            send_char(8'd0);
            send_char(NEWLINE_CODE);
            send_char(8'd255);
        end
    endtask

    // The cursor row and the cell column both stop at their maximum.
    task automatic test_cursor_saturation();
        write_line_pitch(6'd63);
        send_start(9'd0, 8'd200, COLOR_W'($urandom));
        for (int n = 0; n < 17; n++)
            send_char(NEWLINE_CODE);
        send_char(8'd0);
        write_line_pitch(6'd10);
        send_start(9'd0, SY_W'($urandom_range(0, SCREEN_ROWS - 1)), COLOR_W'($urandom));
        for (int n = 0; n < 68; n++)
            send_char(8'd255);
        send_char(NEWLINE_CODE);
        send_char(8'd255);
    endtask

    // Random text runs, glyph loads and noise.
    task automatic random_text_phase(input int item_goal);
        int                sent;
        int                pick;
        int                run_len;
        logic [CODE_W-1:0] code;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_start(random_origin_x(), random_origin_y(), COLOR_W'($urandom));
                run_len = $urandom_range(1, 12);
                for (int k = 0; k < run_len; k++)
                    send_char(random_text_code());
                sent += run_len + 1;
            end else if (pick < 80) begin
                code = CODE_W'($urandom);
                for (int r = 0; r < GLYPH_SIDE; r++)
                    send_load(code, ROW_W'(r), BITS_W'($urandom));
                sent += GLYPH_SIDE;
            end else if (pick < 88) begin
                send_load(CODE_W'($urandom), ROW_W'($urandom), BITS_W'($urandom));
                sent++;
            end else if (pick < 95) begin
                send_char(random_text_code());
                sent++;
            end else begin
                send_item(KIND_UNUSED, pack_item(CODE_W'($urandom), ROW_W'($urandom),
                                                 BITS_W'($urandom), SX_W'($urandom),
                                                 SY_W'($urandom), COLOR_W'($urandom)));
            end
        end
    endtask

    task automatic test_random_text();
        write_line_pitch(PITCH_W'($urandom_range(8, 32)));
        random_text_phase(50);
        // Hold the input back until the block has written everything out.
        wait_until_quiet();
        random_text_phase(50);
        write_line_pitch(PITCH_W'($urandom));
        no_idle = 1'b1;
        random_text_phase(100);
        no_idle = 1'b0;
        write_line_pitch(PITCH_W'($urandom_range(8, 32)));
        random_text_phase(60);
    endtask

    initial begin
        int waited;
        reset_dut();
        test_directed_glyphs();
        test_line_pitch_extremes();
        test_cursor_saturation();
        test_random_text();

        // Drain the remaining writes, then watch for stray ones.
        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $display("%0d expected writes never came", expected_pixels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
